// ===== sv/sdcd_pkg.sv =====
// shared widths and constants for the sd clock divider select block
package sdcd_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] OSC_HZ       = 32'd24000000;
    localparam logic [DATA_W-1:0] F_SLOW_HZ    = 32'd400000;
    localparam logic [DATA_W-1:0] F_MID_HZ     = 32'd25000000;
    localparam logic [DATA_W-1:0] F_FAST_HZ    = 32'd50000000;
    localparam logic [DATA_W-1:0] PLL_RESET_HZ = 32'd600000000;

    localparam logic [DATA_W:0] DIV_MAX = 33'd16;
    localparam logic [1:0]      EXP_MAX = 2'd3;

    // out delay / sample delay codes
    localparam logic [1:0] OD_NONE = 2'd0;
    localparam logic [1:0] OD_FAST = 2'd1;
    localparam logic [1:0] OD_HIGH = 2'd3;
    localparam logic [2:0] SD_NONE = 3'd0;
    localparam logic [2:0] SD_HIGH = 3'd4;
    localparam logic [2:0] SD_MID  = 3'd5;

endpackage

// ===== sv/sd_clock_divider_select_top.sv =====
// sd card clock source, prescaler, divider and delay code selection
//
// usage: the configuration channel (cfg_valid/cfg_ready/cfg_data) sets the pll rate
// in hertz; cfg_ready is always high. write it only while the block is idle.
// a request (s_request_hz) is taken on s_valid && s_ready. one result comes
// out on the m_ channel with m_valid/m_ready.
// a zero request goes straight to the done step and is loaded into the output
// register from there; otherwise the 32-bit serial divider runs, the divider
// is halved (rounding up) up to three times while above 16, and the result is
// loaded into the output register. s_ready is low from acceptance until the
// result has moved into the output register, so one request is worked on at
// a time; a new request can be taken while a result waits.
// if the receiver stalls, the result holds in the output register and the
// next finished result waits in the last step until that register frees.
// reset: synchronous, active low; pll rate returns to 600 MHz, no result
// is pending and the block is ready.
module sd_clock_divider_select_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sdcd_pkg::DATA_W-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sdcd_pkg::DATA_W-1:0] s_request_hz,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_use_pll,
    output logic [1:0]                  m_prescale_exp,
    output logic [4:0]                  m_divider,
    output logic [1:0]                  m_out_delay,
    output logic [2:0]                  m_sample_delay,
    output logic                        m_error
);
    import sdcd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_HALVE = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [DATA_W-1:0] pll_reg, pll_next;
    logic [DATA_W-1:0] req_reg, req_next;
    logic              sel_reg, sel_next;
    logic [DATA_W:0]   div_reg, div_next;
    logic [1:0]        n_reg, n_next;
    logic              err_reg, err_next;

    logic              mv_reg, mv_next;
    logic              o_pll_reg, o_pll_next;
    logic [1:0]        o_n_reg, o_n_next;
    logic [4:0]        o_div_reg, o_div_next;
    logic [1:0]        o_od_reg, o_od_next;
    logic [2:0]        o_sd_reg, o_sd_next;
    logic              o_err_reg, o_err_next;

    logic              accept;
    logic              in_osc;
    logic              dv_done;
    logic [DATA_W-1:0] dv_quo;
    logic              dv_rem_nz;
    logic [DATA_W+1:0] div_inc;
    logic              load_out;
    logic [1:0]        od_code;
    logic [2:0]        sd_code;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign in_osc    = (s_request_hz <= OSC_HZ);

    sdcd_divider u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (accept && (s_request_hz != '0)),
        .dividend    (in_osc ? OSC_HZ : pll_reg),
        .divisor     (s_request_hz),
        .done        (dv_done),
        .quotient    (dv_quo),
        .rem_nonzero (dv_rem_nz)
    );

    assign div_inc  = {1'b0, div_reg} + 1'b1;
    assign load_out = (state_reg == ST_DONE) && (!mv_reg || m_ready);

    always_comb begin
        if (req_reg <= F_SLOW_HZ) begin
            od_code = OD_NONE;
            sd_code = SD_NONE;
        end else if (req_reg <= F_MID_HZ) begin
            od_code = OD_NONE;
            sd_code = SD_MID;
        end else if (req_reg <= F_FAST_HZ) begin
            od_code = OD_HIGH;
            sd_code = SD_HIGH;
        end else begin
            od_code = OD_FAST;
            sd_code = SD_HIGH;
        end
    end

    always_comb begin
        state_next = state_reg;
        pll_next   = pll_reg;
        req_next   = req_reg;
        sel_next   = sel_reg;
        div_next   = div_reg;
        n_next     = n_reg;
        err_next   = err_reg;
        if (cfg_valid) begin
            pll_next = cfg_data;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next = s_request_hz;
                    sel_next = !in_osc;
                    n_next   = '0;
                    if (s_request_hz == '0) begin
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        err_next   = 1'b0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (dv_done) begin
                    // ceiling of the quotient
                    div_next   = {1'b0, dv_quo} + {{DATA_W{1'b0}}, dv_rem_nz};
                    state_next = ST_HALVE;
                end
            end
            ST_HALVE: begin
                if (div_reg > DIV_MAX) begin
                    if (n_reg == EXP_MAX) begin
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        n_next   = n_reg + 1'b1;
                        div_next = div_inc[DATA_W+1:1];
                    end
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pll_next = o_pll_reg;
        o_n_next   = o_n_reg;
        o_div_next = o_div_reg;
        o_od_next  = o_od_reg;
        o_sd_next  = o_sd_reg;
        o_err_next = o_err_reg;
        mv_next    = mv_reg && !m_ready;
        if (load_out) begin
            mv_next = 1'b1;
            if (err_reg) begin
                o_pll_next = 1'b0;
                o_n_next   = '0;
                o_div_next = '0;
                o_od_next  = OD_NONE;
                o_sd_next  = SD_NONE;
                o_err_next = 1'b1;
            end else begin
                o_pll_next = sel_reg;
                o_n_next   = n_reg;
                o_div_next = div_reg[4:0];
                o_od_next  = od_code;
                o_sd_next  = sd_code;
                o_err_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        sel_reg   <= sel_next;
        div_reg   <= div_next;
        n_reg     <= n_next;
        err_reg   <= err_next;
        o_pll_reg <= o_pll_next;
        o_n_reg   <= o_n_next;
        o_div_reg <= o_div_next;
        o_od_reg  <= o_od_next;
        o_sd_reg  <= o_sd_next;
        o_err_reg <= o_err_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pll_reg   <= PLL_RESET_HZ;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            pll_reg   <= pll_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid        = mv_reg;
    assign m_use_pll      = o_pll_reg;
    assign m_prescale_exp = o_n_reg;
    assign m_divider      = o_div_reg;
    assign m_out_delay    = o_od_reg;
    assign m_sample_delay = o_sd_reg;
    assign m_error        = o_err_reg;

endmodule

// ===== sv/sdcd_divider.sv =====
// restoring divider, one quotient bit per cycle
module sdcd_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sdcd_pkg::DATA_W-1:0] dividend,
    input  logic [sdcd_pkg::DATA_W-1:0] divisor,
    output logic                        done,
    output logic [sdcd_pkg::DATA_W-1:0] quotient,
    output logic                        rem_nonzero
);
    import sdcd_pkg::*;

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[DATA_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // no borrow means the divisor fits
            if (!diff[DATA_W]) begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done        = done_reg;
    assign quotient    = quo_reg;
    assign rem_nonzero = |rem_reg;

endmodule
